>>> src/priority_inheriting_mutex_unit_assert.svh
// assertion macros shared by the mutex unit modules
`ifndef PRIORITY_INHERITING_MUTEX_UNIT_ASSERT_SVH
`define PRIORITY_INHERITING_MUTEX_UNIT_ASSERT_SVH

// implication checked on every edge out of reset
`define PIMU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define PIMU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pimu_pkg.sv
// ----------------------------------------------------------------------------
// pimu_pkg
// Types, codes and sizes shared by the priority inheriting mutex unit.
// ----------------------------------------------------------------------------
package pimu_pkg;

    localparam int MUTEX_SLOTS = 16;
    localparam int TASK_SLOTS  = 16;
    localparam int MID_W       = 4;
    localparam int TID_W       = 4;
    localparam int PRIO_W      = 8;
    localparam int AGE_W       = 5;
    localparam int DEPTH_W     = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;

    typedef enum logic [2:0] {
        KIND_CREATE = 3'd0,
        KIND_DELETE = 3'd1,
        KIND_LOCK   = 3'd2,
        KIND_UNLOCK = 3'd3,
        KIND_QUERY  = 3'd4,
        KIND_REMOVE = 3'd5,
        KIND_BAD6   = 3'd6,
        KIND_BAD7   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_BUSY     = 3'd2,
        ST_ERROR    = 3'd3,
        ST_TIMEOUT  = 3'd4,
        ST_BLOCKED  = 3'd5,
        ST_DEADLOCK = 3'd6,
        ST_NO_SLOT  = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_WAKE_OWN = 2'd1,
        EV_WAKE_ERR = 2'd2,
        EV_SET_PRIO = 2'd3
    } event_t;

    typedef enum logic {
        CFG_SCHED_RUNNING = 1'b0,
        CFG_RECURSIVE     = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [MID_W-1:0]  mutex_id;
        logic [TID_W-1:0]  task_id;
        logic [PRIO_W-1:0] task_priority;
        logic              no_wait;
    } req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [1:0]        event_res;
        logic [TID_W-1:0]  event_task;
        logic [PRIO_W-1:0] event_priority;
        logic [MID_W-1:0]  handle;
        logic [TID_W-1:0]  owner_task;
        logic              owner_valid;
        logic              last;
    } rsp_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DECIDE,
        BK_SCAN,
        BK_ACT,
        BK_EMIT
    } bk_state_t;

    // queue status between front and back
    typedef struct packed {
        logic valid;
        logic ready;
    } q_hs_t;

endpackage

>>> src/pimu_front.sv
// ----------------------------------------------------------------------------
// pimu_front
// Accepts items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pimu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  pimu_pkg::req_t s_data,
    output pimu_pkg::req_t q_data,
    output pimu_pkg::q_hs_t q_hs,
    input  logic          q_pop
);
    import pimu_pkg::*;

    req_t       mem_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign s_ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && (cnt_reg != 2'd0);
    assign q_hs.valid = (cnt_reg != 2'd0);
    assign q_hs.ready = s_ready;
    assign q_data  = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_data;
        end
    end

`include "priority_inheriting_mutex_unit_assert.svh"
    `PIMU_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_reg <= 2'(QUEUE_DEPTH), "queue count overflow")
    `PIMU_ASSERT_NEXT(a_push_cnt, push && !pop, cnt_reg == $past(cnt_reg) + 2'd1, "push lost")
    `PIMU_ASSERT_NEXT(a_pop_cnt, pop && !push, cnt_reg == $past(cnt_reg) - 2'd1, "pop lost")

endmodule

>>> src/pimu_back.sv
// ----------------------------------------------------------------------------
// pimu_back
// Executes one operation: scans the waiter table and emits results.
// ----------------------------------------------------------------------------
module pimu_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  pimu_pkg::req_t  q_data,
    input  pimu_pkg::q_hs_t q_hs,
    output logic            q_pop,
    input  logic            cfg_sched,
    input  logic            cfg_recur,
    output logic            m_valid,
    input  logic            m_ready,
    output pimu_pkg::rsp_t  m_data
);
    import pimu_pkg::*;

    // mutex table
    logic                slot_in_use_reg [MUTEX_SLOTS];
    logic                has_owner_reg   [MUTEX_SLOTS];
    logic [TID_W-1:0]    owner_reg       [MUTEX_SLOTS];
    logic [DEPTH_W-1:0]  depth_reg       [MUTEX_SLOTS];
    logic [PRIO_W-1:0]   base_reg        [MUTEX_SLOTS];
    logic [PRIO_W-1:0]   boost_reg       [MUTEX_SLOTS];
    // waiter table
    logic                wv_reg   [TASK_SLOTS];
    logic [MID_W-1:0]    wm_reg   [TASK_SLOTS];
    logic [PRIO_W-1:0]   wp_reg   [TASK_SLOTS];
    logic [AGE_W-1:0]    wa_reg   [TASK_SLOTS];

    bk_state_t state_reg, state_next;
    req_t      op_reg;
    rsp_t      out_reg, out_next;
    logic      out_valid_reg, out_valid_next;
    logic [TID_W:0]   scan_reg, scan_next;
    logic             best_ok_reg, best_ok_next;
    logic [TID_W-1:0] best_reg, best_next;
    logic [AGE_W-1:0] cnt_reg, cnt_next;
    logic             boost_ev_reg, boost_ev_next;

    logic [MID_W-1:0] m;
    logic [TID_W-1:0] tk;
    logic [TID_W-1:0] st;
    logic             slot_ok;
    logic             free_ok;
    logic [MID_W-1:0] free_idx;

    assign m  = op_reg.mutex_id;
    assign tk = op_reg.task_id;
    assign st = scan_reg[TID_W-1:0];
    assign slot_ok = slot_in_use_reg[m];
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // first free slot
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = MUTEX_SLOTS - 1; i >= 0; i--) begin
            if (!slot_in_use_reg[i]) begin
                free_ok  = 1'b1;
                free_idx = MID_W'(i);
            end
        end
    end

    function automatic rsp_t mk(logic [2:0] s, logic [1:0] e, logic [TID_W-1:0] t,
                                logic [PRIO_W-1:0] p, logic l);
        rsp_t r;
        r = '0;
        r.status = s;
        r.event_res = e;
        r.event_task = t;
        r.event_priority = p;
        r.last = l;
        return r;
    endfunction

    logic out_free;
    assign out_free = !out_valid_reg || m_ready;

    // sequencer
    always_comb begin
        state_next     = state_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        scan_next      = scan_reg;
        best_ok_next   = best_ok_reg;
        best_next      = best_reg;
        cnt_next       = cnt_reg;
        boost_ev_next  = boost_ev_reg;
        q_pop          = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (q_hs.valid) begin
                    q_pop      = 1'b1;
                    state_next = BK_DECIDE;
                end
            end
            BK_DECIDE: begin
                scan_next    = '0;
                best_ok_next = 1'b0;
                cnt_next     = '0;
                state_next   = BK_SCAN;
            end
            BK_SCAN: begin
                if (wv_reg[st] && wm_reg[st] == m) begin
                    cnt_next = cnt_reg + AGE_W'(1);
                    if (!best_ok_reg || wp_reg[st] > wp_reg[best_reg] ||
                        (wp_reg[st] == wp_reg[best_reg] && wa_reg[st] < wa_reg[best_reg])) begin
                        best_ok_next = 1'b1;
                        best_next    = st;
                    end
                end
                scan_next = scan_reg + (TID_W+1)'(1);
                if (scan_reg == (TID_W+1)'(TASK_SLOTS - 1)) begin
                    state_next = BK_ACT;
                end
            end
            BK_ACT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                    case (kind_t'(op_reg.kind))
                        KIND_CREATE: begin
                            out_next = mk(free_ok ? ST_OK : ST_NO_SLOT, EV_NONE, '0, '0, 1'b1);
                            out_next.handle = free_ok ? free_idx : '0;
                        end
                        KIND_DELETE: begin
                            if (!slot_ok) out_next = mk(ST_INVALID, EV_NONE, '0, '0, 1'b1);
                            else if (has_owner_reg[m]) out_next = mk(ST_BUSY, EV_NONE, '0, '0, 1'b1);
                            else if (best_ok_reg) begin
                                out_next   = mk(ST_ERROR, EV_WAKE_ERR, best_reg, '0, 1'b0);
                                state_next = BK_DECIDE;
                            end else out_next = mk(ST_OK, EV_NONE, '0, '0, 1'b1);
                        end
                        KIND_LOCK: begin
                            if (!slot_ok) out_next = mk(ST_INVALID, EV_NONE, '0, '0, 1'b1);
                            else if (!cfg_sched || wv_reg[tk])
                                out_next = mk(ST_ERROR, EV_NONE, '0, '0, 1'b1);
                            else if (!has_owner_reg[m]) out_next = mk(ST_OK, EV_NONE, '0, '0, 1'b1);
                            else if (owner_reg[m] == tk) begin
                                if (!cfg_recur) out_next = mk(ST_DEADLOCK, EV_NONE, '0, '0, 1'b1);
                                else if (depth_reg[m] >= DEPTH_MAX)
                                    out_next = mk(ST_ERROR, EV_NONE, '0, '0, 1'b1);
                                else out_next = mk(ST_OK, EV_NONE, '0, '0, 1'b1);
                            end else if (op_reg.no_wait)
                                out_next = mk(ST_TIMEOUT, EV_NONE, '0, '0, 1'b1);
                            else if (op_reg.task_priority > boost_reg[m]) begin
                                out_next = mk(ST_OK, EV_SET_PRIO, owner_reg[m],
                                              op_reg.task_priority, 1'b0);
                                state_next = BK_EMIT;
                                boost_ev_next = 1'b0;
                            end else out_next = mk(ST_BLOCKED, EV_NONE, '0, '0, 1'b1);
                        end
                        KIND_UNLOCK: begin
                            if (!slot_ok) out_next = mk(ST_INVALID, EV_NONE, '0, '0, 1'b1);
                            else if (!cfg_sched || !has_owner_reg[m] || owner_reg[m] != tk)
                                out_next = mk(ST_ERROR, EV_NONE, '0, '0, 1'b1);
                            else if (depth_reg[m] > DEPTH_W'(1))
                                out_next = mk(ST_OK, EV_NONE, '0, '0, 1'b1);
                            else if (boost_reg[m] != base_reg[m]) begin
                                out_next = mk(ST_OK, EV_SET_PRIO, tk, base_reg[m], 1'b0);
                                state_next = BK_EMIT;
                                boost_ev_next = 1'b1;
                            end else if (best_ok_reg) begin
                                out_next = mk(ST_OK, EV_WAKE_OWN, best_reg, '0, 1'b0);
                                state_next = BK_EMIT;
                                boost_ev_next = 1'b0;
                            end else out_next = mk(ST_OK, EV_NONE, '0, '0, 1'b1);
                        end
                        KIND_QUERY: begin
                            if (!slot_ok) out_next = mk(ST_INVALID, EV_NONE, '0, '0, 1'b1);
                            else begin
                                out_next = mk(ST_OK, EV_NONE, '0, '0, 1'b1);
                                out_next.owner_task  = has_owner_reg[m] ? owner_reg[m] : '0;
                                out_next.owner_valid = has_owner_reg[m];
                            end
                        end
                        KIND_REMOVE: begin
                            out_next = mk(wv_reg[tk] ? ST_OK : ST_ERROR, EV_NONE, '0, '0, 1'b1);
                        end
                        default: out_next = mk(ST_ERROR, EV_NONE, '0, '0, 1'b1);
                    endcase
                end
            end
            BK_EMIT: begin
                // follow-up result of lock or unlock
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                    if (kind_t'(op_reg.kind) == KIND_LOCK)
                        out_next = mk(ST_BLOCKED, EV_NONE, '0, '0, 1'b1);
                    else if (boost_ev_reg && best_ok_reg) begin
                        out_next = mk(ST_OK, EV_WAKE_OWN, best_reg, '0, 1'b0);
                        boost_ev_next = 1'b0;
                        state_next = BK_EMIT;
                    end else out_next = mk(ST_OK, EV_NONE, '0, '0, 1'b1);
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg      <= out_next;
        scan_reg     <= scan_next;
        best_ok_reg  <= best_ok_next;
        best_reg     <= best_next;
        cnt_reg      <= cnt_next;
        boost_ev_reg <= boost_ev_next;
        if (q_pop) op_reg <= q_data;
    end

    // table updates, done whenever a result of an item leaves act
    logic act_go;
    assign act_go = (state_reg == BK_ACT) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MUTEX_SLOTS; i++) begin
                slot_in_use_reg[i] <= 1'b0;
                has_owner_reg[i]   <= 1'b0;
                depth_reg[i]       <= '0;
            end
            for (int i = 0; i < TASK_SLOTS; i++) wv_reg[i] <= 1'b0;
        end else if (act_go) begin
            case (kind_t'(op_reg.kind))
                KIND_CREATE: begin
                    if (free_ok) begin
                        slot_in_use_reg[free_idx] <= 1'b1;
                        has_owner_reg[free_idx]   <= 1'b0;
                        depth_reg[free_idx]       <= '0;
                    end
                end
                KIND_DELETE: begin
                    if (slot_ok && !has_owner_reg[m]) begin
                        if (best_ok_reg) begin
                            wv_reg[best_reg] <= 1'b0;
                            for (int i = 0; i < TASK_SLOTS; i++)
                                if (wv_reg[i] && wm_reg[i] == m && wa_reg[i] > wa_reg[best_reg])
                                    wa_reg[i] <= wa_reg[i] - AGE_W'(1);
                        end else begin
                            slot_in_use_reg[m] <= 1'b0;
                            depth_reg[m]       <= '0;
                        end
                    end
                end
                KIND_LOCK: begin
                    if (slot_ok && cfg_sched && !wv_reg[tk]) begin
                        if (!has_owner_reg[m]) begin
                            has_owner_reg[m] <= 1'b1;
                            owner_reg[m]     <= tk;
                            depth_reg[m]     <= DEPTH_W'(1);
                            base_reg[m]      <= op_reg.task_priority;
                            boost_reg[m]     <= op_reg.task_priority;
                        end else if (owner_reg[m] == tk) begin
                            if (cfg_recur && depth_reg[m] < DEPTH_MAX)
                                depth_reg[m] <= depth_reg[m] + DEPTH_W'(1);
                        end else if (!op_reg.no_wait) begin
                            wv_reg[tk] <= 1'b1;
                            wm_reg[tk] <= m;
                            wp_reg[tk] <= op_reg.task_priority;
                            wa_reg[tk] <= cnt_reg;
                            if (op_reg.task_priority > boost_reg[m])
                                boost_reg[m] <= op_reg.task_priority;
                        end
                    end
                end
                KIND_UNLOCK: begin
                    if (slot_ok && cfg_sched && has_owner_reg[m] && owner_reg[m] == tk) begin
                        if (depth_reg[m] > DEPTH_W'(1))
                            depth_reg[m] <= depth_reg[m] - DEPTH_W'(1);
                        else if (best_ok_reg) begin
                            wv_reg[best_reg] <= 1'b0;
                            for (int i = 0; i < TASK_SLOTS; i++)
                                if (wv_reg[i] && wm_reg[i] == m && wa_reg[i] > wa_reg[best_reg])
                                    wa_reg[i] <= wa_reg[i] - AGE_W'(1);
                            owner_reg[m] <= best_reg;
                            depth_reg[m] <= DEPTH_W'(1);
                            base_reg[m]  <= wp_reg[best_reg];
                            boost_reg[m] <= wp_reg[best_reg];
                        end else begin
                            depth_reg[m]     <= '0;
                            boost_reg[m]     <= base_reg[m];
                            has_owner_reg[m] <= 1'b0;
                        end
                    end
                end
                KIND_REMOVE: begin
                    if (wv_reg[tk]) begin
                        wv_reg[tk] <= 1'b0;
                        for (int i = 0; i < TASK_SLOTS; i++)
                            if (wv_reg[i] && wm_reg[i] == wm_reg[tk] && wa_reg[i] > wa_reg[tk])
                                wa_reg[i] <= wa_reg[i] - AGE_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

`include "priority_inheriting_mutex_unit_assert.svh"
    `PIMU_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped")
    `PIMU_ASSERT_IMPL(a_pop_idle, q_pop, state_reg == BK_IDLE, "pop while busy")
    `PIMU_ASSERT_IMPL(a_evt_notlast, m_valid && m_data.event_res != EV_NONE, !m_data.last, "event marked last")

endmodule

>>> src/priority_inheriting_mutex_unit.sv
// ----------------------------------------------------------------------------
// priority_inheriting_mutex_unit
// Recursive mutex table with priority inheritance for a real-time kernel.
// ----------------------------------------------------------------------------
// An operation with a single result passes through the back end in steps: it
// takes the item from the queue, sets up, walks the 16 waiter entries,
// one per cycle, to count waiters and find the head waiter, and then
// registers the result. Each further result of a lock or unlock is registered
// from the emit state, and every result waits for m_ready. A delete repeats
// the setup and the walk for each waiter it wakes. A two-entry
// queue in front accepts items while the back end works.
module priority_inheriting_mutex_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [0:0]     cfg_index,
    input  logic [0:0]     cfg_data,
    input  logic           s_valid,
    output logic           s_ready,
    input  pimu_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pimu_pkg::rsp_t m_data
);
    import pimu_pkg::*;

    logic   sched_reg, recur_reg;
    req_t   q_data;
    q_hs_t  q_hs;
    logic   q_pop;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sched_reg <= 1'b0;
            recur_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_SCHED_RUNNING: sched_reg <= cfg_data[0];
                CFG_RECURSIVE:     recur_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    pimu_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_data(s_data), .q_data(q_data), .q_hs(q_hs), .q_pop(q_pop)
    );

    pimu_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_data(q_data), .q_hs(q_hs), .q_pop(q_pop),
        .cfg_sched(sched_reg), .cfg_recur(recur_reg), .m_valid(m_valid),
        .m_ready(m_ready), .m_data(m_data)
    );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the priority inheriting mutex unit against a behavioral predictor:
// directed cases for every operation and error path, then random runs of
// mutex sequences under several idle and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
    import pimu_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [0:0] cfg_data;
    logic       s_valid;
    logic       s_ready;
    req_t       s_data;
    logic       m_valid;
    logic       m_ready;
    rsp_t       m_data;

    priority_inheriting_mutex_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // predictor state
    bit                sched_on;
    bit                nest_ok;
    bit                slot_used [MUTEX_SLOTS];
    bit                owned     [MUTEX_SLOTS];
    logic [TID_W-1:0]  owner     [MUTEX_SLOTS];
    logic [7:0]        depth     [MUTEX_SLOTS];
    logic [PRIO_W-1:0] base_pr   [MUTEX_SLOTS];
    logic [PRIO_W-1:0] cur_pr    [MUTEX_SLOTS];
    bit                waiting   [TASK_SLOTS];
    logic [MID_W-1:0]  wait_mtx  [TASK_SLOTS];
    logic [PRIO_W-1:0] wait_pr   [TASK_SLOTS];
    int                wait_rank [TASK_SLOTS];

    rsp_t expected_rsps[$];
    int   fail_count;
    int   cycle_count;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off_cycles;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver readiness
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsps.size() == 0) begin
                $display("%0t unexpected result %p", $time, m_data);
                fail_count++;
            end else begin
                want = expected_rsps.pop_front();
                if (m_data !== want) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, m_data);
                    fail_count++;
                end
            end
        end
    end

    function automatic rsp_t mk_rsp(status_t st, event_t ev, logic [3:0] tsk,
                                    logic [7:0] pr, bit fin);
        rsp_t r;
        r = '0;
        r.status = st;
        r.event_res = ev;
        r.event_task = tsk;
        r.event_priority = pr;
        r.last = fin;
        return r;
    endfunction

    function automatic int find_head_waiter(logic [3:0] m);
        int best;
        best = -1;
        for (int t = 0; t < TASK_SLOTS; t++) begin
            if (waiting[t] && wait_mtx[t] == m) begin
                if (best < 0 || wait_pr[t] > wait_pr[best] ||
                    (wait_pr[t] == wait_pr[best] && wait_rank[t] < wait_rank[best]))
                    best = t;
            end
        end
        return best;
    endfunction

    function automatic void unqueue_waiter(int w);
        waiting[w] = 0;
        for (int t = 0; t < TASK_SLOTS; t++)
            if (waiting[t] && wait_mtx[t] == wait_mtx[w] && wait_rank[t] > wait_rank[w])
                wait_rank[t]--;
    endfunction

    // predicted results of one operation, queued in order
    function automatic void predict_mutex_op(req_t rq);
        int   w, cnt;
        rsp_t r;
        logic [3:0] m;
        logic [3:0] tk;
        m = rq.mutex_id;
        tk = rq.task_id;
        case (kind_t'(rq.kind))
            KIND_CREATE: begin
                for (int s = 0; s < MUTEX_SLOTS; s++) begin
                    if (!slot_used[s]) begin
                        slot_used[s] = 1;
                        owned[s] = 0;
                        depth[s] = 0;
                        r = mk_rsp(ST_OK, EV_NONE, 4'd0, 8'd0, 1);
                        r.handle = 4'(s);
                        expected_rsps.push_back(r);
                        return;
                    end
                end
                expected_rsps.push_back(mk_rsp(ST_NO_SLOT, EV_NONE, 4'd0, 8'd0, 1));
            end
            KIND_DELETE: begin
                if (!slot_used[m])
                    expected_rsps.push_back(mk_rsp(ST_INVALID, EV_NONE, 4'd0, 8'd0, 1));
                else if (owned[m])
                    expected_rsps.push_back(mk_rsp(ST_BUSY, EV_NONE, 4'd0, 8'd0, 1));
                else begin
                    w = find_head_waiter(m);
                    while (w >= 0) begin
                        unqueue_waiter(w);
                        expected_rsps.push_back(mk_rsp(ST_ERROR, EV_WAKE_ERR, 4'(w), 8'd0, 0));
                        w = find_head_waiter(m);
                    end
                    slot_used[m] = 0;
                    depth[m] = 0;
                    expected_rsps.push_back(mk_rsp(ST_OK, EV_NONE, 4'd0, 8'd0, 1));
                end
            end
            KIND_LOCK: begin
                if (!slot_used[m])
                    expected_rsps.push_back(mk_rsp(ST_INVALID, EV_NONE, 4'd0, 8'd0, 1));
                else if (!sched_on || waiting[tk])
                    expected_rsps.push_back(mk_rsp(ST_ERROR, EV_NONE, 4'd0, 8'd0, 1));
                else if (!owned[m]) begin
                    owned[m] = 1;
                    owner[m] = tk;
                    depth[m] = 1;
                    base_pr[m] = rq.task_priority;
                    cur_pr[m] = rq.task_priority;
                    expected_rsps.push_back(mk_rsp(ST_OK, EV_NONE, 4'd0, 8'd0, 1));
                end else if (owner[m] == tk) begin
                    if (!nest_ok)
                        expected_rsps.push_back(mk_rsp(ST_DEADLOCK, EV_NONE, 4'd0, 8'd0, 1));
                    else if (depth[m] == 8'd255)
                        expected_rsps.push_back(mk_rsp(ST_ERROR, EV_NONE, 4'd0, 8'd0, 1));
                    else begin
                        depth[m]++;
                        expected_rsps.push_back(mk_rsp(ST_OK, EV_NONE, 4'd0, 8'd0, 1));
                    end
                end else if (rq.no_wait)
                    expected_rsps.push_back(mk_rsp(ST_TIMEOUT, EV_NONE, 4'd0, 8'd0, 1));
                else begin
                    cnt = 0;
                    for (int t = 0; t < TASK_SLOTS; t++)
                        if (waiting[t] && wait_mtx[t] == m) cnt++;
                    waiting[tk] = 1;
                    wait_mtx[tk] = m;
                    wait_pr[tk] = rq.task_priority;
                    wait_rank[tk] = cnt;
                    if (rq.task_priority > cur_pr[m]) begin
                        cur_pr[m] = rq.task_priority;
                        expected_rsps.push_back(
                            mk_rsp(ST_OK, EV_SET_PRIO, owner[m], rq.task_priority, 0));
                    end
                    expected_rsps.push_back(mk_rsp(ST_BLOCKED, EV_NONE, 4'd0, 8'd0, 1));
                end
            end
            KIND_UNLOCK: begin
                if (!slot_used[m])
                    expected_rsps.push_back(mk_rsp(ST_INVALID, EV_NONE, 4'd0, 8'd0, 1));
                else if (!sched_on || !owned[m] || owner[m] != tk)
                    expected_rsps.push_back(mk_rsp(ST_ERROR, EV_NONE, 4'd0, 8'd0, 1));
                else if (depth[m] > 1) begin
                    depth[m]--;
                    expected_rsps.push_back(mk_rsp(ST_OK, EV_NONE, 4'd0, 8'd0, 1));
                end else begin
                    depth[m] = 0;
                    if (cur_pr[m] != base_pr[m]) begin
                        cur_pr[m] = base_pr[m];
                        expected_rsps.push_back(mk_rsp(ST_OK, EV_SET_PRIO, tk, base_pr[m], 0));
                    end
                    w = find_head_waiter(m);
                    if (w >= 0) begin
                        unqueue_waiter(w);
                        owner[m] = 4'(w);
                        depth[m] = 1;
                        base_pr[m] = wait_pr[w];
                        cur_pr[m] = wait_pr[w];
                        expected_rsps.push_back(mk_rsp(ST_OK, EV_WAKE_OWN, 4'(w), 8'd0, 0));
                    end else
                        owned[m] = 0;
                    expected_rsps.push_back(mk_rsp(ST_OK, EV_NONE, 4'd0, 8'd0, 1));
                end
            end
            KIND_QUERY: begin
                r = mk_rsp(slot_used[m] ? ST_OK : ST_INVALID, EV_NONE, 4'd0, 8'd0, 1);
                if (slot_used[m] && owned[m]) begin
                    r.owner_task = owner[m];
                    r.owner_valid = 1;
                end
                expected_rsps.push_back(r);
            end
            KIND_REMOVE: begin
                if (!waiting[tk])
                    expected_rsps.push_back(mk_rsp(ST_ERROR, EV_NONE, 4'd0, 8'd0, 1));
                else begin
                    unqueue_waiter(tk);
                    expected_rsps.push_back(mk_rsp(ST_OK, EV_NONE, 4'd0, 8'd0, 1));
                end
            end
            default: expected_rsps.push_back(mk_rsp(ST_ERROR, EV_NONE, 4'd0, 8'd0, 1));
        endcase
    endfunction

    // offer one item, predict it on acceptance
    task automatic send_op(kind_t k, int m, int tk, int pr, bit nw);
        req_t rq;
        rq.kind = k;
        rq.mutex_id = 4'(m);
        rq.task_id = 4'(tk);
        rq.task_priority = 8'(pr);
        rq.no_wait = nw;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= rq;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_mutex_op(rq);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_rsps.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, bit v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SCHED_RUNNING) sched_on = v;
        else nest_ok = v;
    endtask

    // operations and error paths with the scheduler off and on
    task automatic test_directed();
        send_op(KIND_LOCK, 0, 1, 10, 0);
        send_op(KIND_CREATE, 9, 0, 0, 0);
        send_op(KIND_LOCK, 0, 1, 10, 0);
        write_reg(CFG_SCHED_RUNNING, 1);
        send_op(KIND_LOCK, 0, 1, 0, 0);
        send_op(KIND_LOCK, 0, 1, 0, 0);
        send_op(KIND_LOCK, 0, 2, 255, 1);
        send_op(KIND_LOCK, 0, 2, 255, 0);
        send_op(KIND_LOCK, 0, 2, 5, 0);
        send_op(KIND_LOCK, 0, 15, 200, 0);
        send_op(KIND_QUERY, 0, 0, 0, 0);
        send_op(KIND_QUERY, 15, 0, 0, 0);
        send_op(KIND_DELETE, 0, 0, 0, 0);
        send_op(KIND_UNLOCK, 0, 3, 0, 0);
        send_op(KIND_UNLOCK, 0, 1, 0, 0);
        send_op(KIND_UNLOCK, 0, 1, 0, 0);
        send_op(KIND_REMOVE, 7, 14, 0, 0);
        send_op(KIND_REMOVE, 0, 15, 0, 0);
        send_op(KIND_BAD6, 0, 0, 0, 0);
        send_op(KIND_BAD7, 15, 15, 255, 1);
        send_op(KIND_UNLOCK, 0, 2, 0, 0);
        send_op(KIND_UNLOCK, 0, 1, 0, 0);
        send_op(KIND_DELETE, 0, 0, 0, 0);
        send_op(KIND_UNLOCK, 5, 1, 0, 0);
        write_reg(CFG_RECURSIVE, 0);
        send_op(KIND_CREATE, 0, 0, 0, 0);
        send_op(KIND_LOCK, 0, 4, 9, 0);
        send_op(KIND_LOCK, 0, 4, 9, 0);
        write_reg(CFG_RECURSIVE, 1);
    endtask

    // full table then a delete with several waiters
    task automatic test_table_full();
        for (int i = 0; i < 17; i++) send_op(KIND_CREATE, 0, 0, 0, 0);
        send_op(KIND_LOCK, 3, 0, 50, 0);
        for (int t = 1; t < 6; t++) send_op(KIND_LOCK, 3, t, $urandom_range(255), 0);
        send_op(KIND_UNLOCK, 3, 0, 0, 0);
        send_op(KIND_QUERY, 3, 0, 0, 0);
        for (int t = 1; t < 6; t++) send_op(KIND_UNLOCK, 3, t, 0, 0);
        send_op(KIND_LOCK, 3, 8, 50, 0);
        for (int t = 9; t < 13; t++) send_op(KIND_LOCK, 3, t, 50, 0);
        send_op(KIND_UNLOCK, 3, 8, 0, 0);
        send_op(KIND_UNLOCK, 3, 9, 0, 0);
        send_op(KIND_DELETE, 3, 0, 0, 0);
        for (int m = 0; m < MUTEX_SLOTS; m++) begin
            if (owned[m]) send_op(KIND_UNLOCK, m, owner[m], 0, 0);
            while (owned[m]) send_op(KIND_UNLOCK, m, owner[m], 0, 0);
        end
        for (int m = 2; m < MUTEX_SLOTS; m++) send_op(KIND_DELETE, m, 0, 0, 0);
    endtask

    // lock depth saturation, then a short unwind
    task automatic test_depth_limit();
        for (int i = 0; i < 256; i++) send_op(KIND_LOCK, 1, 6, 30, 0);
        for (int i = 0; i < 2; i++) send_op(KIND_UNLOCK, 1, 6, 0, 0);
    endtask

    // random mix biased toward legal lock and unlock sequences
    task automatic test_random_mix(int count);
        int k, m, tk;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(99);
            m = $urandom_range(3);
            tk = $urandom_range(15);
            if ($urandom_range(9) == 0) m = $urandom_range(15);
            if (k < 8) send_op(KIND_CREATE, $urandom_range(15), tk, 0, 0);
            else if (k < 14) send_op(KIND_DELETE, m, tk, 0, 0);
            else if (k < 50)
                send_op(KIND_LOCK, m, tk, $urandom_range(255), $urandom_range(5) == 0);
            else if (k < 78) begin
                if (slot_used[m] && owned[m] && $urandom_range(3) != 0) tk = owner[m];
                send_op(KIND_UNLOCK, m, tk, $urandom_range(255), $urandom_range(1));
            end else if (k < 86) send_op(KIND_QUERY, m, tk, 0, 0);
            else if (k < 96) send_op(KIND_REMOVE, m, tk, 0, 0);
            else send_op(kind_t'($urandom_range(7)), m, tk, $urandom_range(255), 1);
        end
    endtask

    // receiver holds off while items keep coming, then sender waits for all
    task automatic test_backpressure();
        hold_off_cycles = 400;
        test_random_mix(12);
        wait_drained();
    endtask

    initial begin
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        sched_on = 0;
        nest_ok = 1;
        foreach (slot_used[i]) begin
            slot_used[i] = 0;
            owned[i] = 0;
            depth[i] = 0;
        end
        foreach (waiting[i]) waiting[i] = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_table_full();
        test_depth_limit();
        test_random_mix(30);
        send_idle_pct = 48;
        test_random_mix(30);
        send_idle_pct = 0;
        recv_stall_pct = 48;
        test_random_mix(30);
        write_reg(CFG_RECURSIVE, 0);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        test_random_mix(30);
        test_backpressure();
        write_reg(CFG_RECURSIVE, 1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_mix(20);
        write_reg(CFG_SCHED_RUNNING, 0);
        test_random_mix(10);

        wait_drained();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> priority_inheriting_mutex_unit.f
+incdir+src
src/pimu_pkg.sv
src/pimu_front.sv
src/pimu_back.sv
src/priority_inheriting_mutex_unit.sv
tb/testbench.sv
